// ----- src/tdpt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_pkg: shared types and constants of the primality tester
// State encoding of the sequencer and the trial divisor constants.
// ----------------------------------------------------------------------------
package tdpt_pkg;

   localparam int unsigned FIRST_DIVISOR = 3;
   localparam int unsigned DIVISOR_STEP  = 2;
   localparam int unsigned SMALLEST_PRIME = 2;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_START  = 4'b0010,
      ST_RUN    = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

endpackage

// ----- src/tdpt_channels.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt channels: valid/ready channels of the primality tester
// Request channel carries the candidate, response channel the verdict.
// ----------------------------------------------------------------------------
interface tdpt_req_if #(
   parameter int NUMBER_WIDTH = 32
);
   logic                    valid;
   logic                    ready;
   logic [NUMBER_WIDTH-1:0] candidate;

   modport source (output valid, output candidate, input ready);
   modport sink   (input valid, input candidate, output ready);
endinterface

interface tdpt_rsp_if;
   logic valid;
   logic ready;
   logic prime_flag;

   modport source (output valid, output prime_flag, input ready);
   modport sink   (input valid, input prime_flag, output ready);
endinterface

// ----- src/tdpt_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_divider: bit-serial restoring divider
// One quotient bit per cycle; quotient and remainder valid while done is high.
// ----------------------------------------------------------------------------
module tdpt_divider #(
   parameter int NUMBER_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [NUMBER_WIDTH-1:0] dividend,
   input  logic [NUMBER_WIDTH-1:0] divisor,
   output logic                    done,
   output logic [NUMBER_WIDTH-1:0] quotient,
   output logic [NUMBER_WIDTH-1:0] remainder
);

   localparam int CW = (NUMBER_WIDTH > 1) ? $clog2(NUMBER_WIDTH) : 1;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [NUMBER_WIDTH-1:0] shift_ff, shift_in;
   logic [NUMBER_WIDTH-1:0] rem_ff, rem_in;
   logic [NUMBER_WIDTH:0]   trial;
   logic [NUMBER_WIDTH:0]   diff;

   // bring down the next dividend bit and try the subtraction
   assign trial = {rem_ff, shift_ff[NUMBER_WIDTH-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CW'(NUMBER_WIDTH - 1);
         shift_in = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         if (diff[NUMBER_WIDTH]) begin
            rem_in   = trial[NUMBER_WIDTH-1:0];
            shift_in = {shift_ff[NUMBER_WIDTH-2:0], 1'b0};
         end else begin
            rem_in   = diff[NUMBER_WIDTH-1:0];
            shift_in = {shift_ff[NUMBER_WIDTH-2:0], 1'b1};
         end
         count_in = count_ff - CW'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = shift_ff;
   assign remainder = rem_ff;

endmodule

// ----- src/trial_division_prime_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_prime_test: primality test by trial division
// Takes one unsigned candidate per item and answers whether it is prime.
// ----------------------------------------------------------------------------
// Candidates below two, and even candidates other than two, are answered
// without division and pass through ST_FINISH into the response register.
// An odd candidate n is divided by 3, 5, 7, ... until one divides it or the
// divisor exceeds floor(n / divisor); each trial divisor is launched in
// ST_START, worked off by the bit-serial divider, which yields one quotient
// bit per cycle, and judged in ST_RUN once the divider is done. A prime near
// 2^NUMBER_WIDTH therefore needs about 2^(NUMBER_WIDTH/2 - 1) trial divisors.
// One item is worked on at a time; the next item is accepted once the
// previous verdict has moved into the response register, even while that
// verdict still waits there.
// ----------------------------------------------------------------------------
module trial_division_prime_test #(
   parameter int NUMBER_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   tdpt_req_if.sink   req_chan,
   tdpt_rsp_if.source rsp_chan
);

   import tdpt_pkg::*;

   localparam logic [NUMBER_WIDTH-1:0] FIRST_D = NUMBER_WIDTH'(FIRST_DIVISOR);
   localparam logic [NUMBER_WIDTH-1:0] STEP_D  = NUMBER_WIDTH'(DIVISOR_STEP);
   localparam logic [NUMBER_WIDTH-1:0] TWO     = NUMBER_WIDTH'(SMALLEST_PRIME);

   state_type               state_ff, state_in;
   logic [NUMBER_WIDTH-1:0] number_ff, number_in;
   logic [NUMBER_WIDTH-1:0] divisor_ff, divisor_in;
   logic                    verdict_ff, verdict_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_flag_ff, rsp_flag_in;

   logic                    div_start;
   logic                    div_done;
   logic [NUMBER_WIDTH-1:0] div_quotient;
   logic [NUMBER_WIDTH-1:0] div_remainder;
   logic                    accept;
   logic                    slot_free;

   // the shared serial divider: n / d and n % d
   tdpt_divider #(
      .NUMBER_WIDTH(NUMBER_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (number_ff),
      .divisor   (divisor_ff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign div_start      = (state_ff == ST_START);
   // the response register can take a verdict when empty or being drained
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      number_in    = number_ff;
      divisor_in   = divisor_ff;
      verdict_in   = verdict_ff;
      rsp_flag_in  = rsp_flag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               number_in  = req_chan.candidate;
               divisor_in = FIRST_D;
               if (req_chan.candidate[NUMBER_WIDTH-1:1] == '0) begin
                  // zero and one are not prime
                  verdict_in = 1'b0;
                  state_in   = ST_FINISH;
               end else if (req_chan.candidate == TWO) begin
                  verdict_in = 1'b1;
                  state_in   = ST_FINISH;
               end else if (!req_chan.candidate[0]) begin
                  // every other even value is composite
                  verdict_in = 1'b0;
                  state_in   = ST_FINISH;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            // launch the divider this cycle
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (div_done) begin
               if (div_quotient < divisor_ff) begin
                  // divisor has passed the square root: no factor found
                  verdict_in = 1'b1;
                  state_in   = ST_FINISH;
               end else if (div_remainder == '0) begin
                  verdict_in = 1'b0;
                  state_in   = ST_FINISH;
               end else begin
                  // advance to the next odd divisor
                  divisor_in = divisor_ff + STEP_D;
                  state_in   = ST_START;
               end
            end
         end
         ST_FINISH: begin
            // hold the verdict until the response register is free
            if (slot_free) begin
               rsp_flag_in  = verdict_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      number_ff   <= number_in;
      divisor_ff  <= divisor_in;
      verdict_ff  <= verdict_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.prime_flag = rsp_flag_ff;

endmodule

// ----- test/tb_trial_division_prime_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trial_division_prime_test: self-checking bench for the primality tester
// Feeds candidates through the request channel, predicts each verdict by
// trial division and checks every response in order, under varied pacing
// on both channels and one long response stall.
// ----------------------------------------------------------------------------
module tb_trial_division_prime_test;

   import tdpt_pkg::*;

   localparam int NUMBER_WIDTH   = 32;
   localparam int RANDOM_ITEMS   = 77;
   // Upper bound on the run length before the bench gives up.
   localparam int CYCLE_LIMIT    = 3_000_000;
   localparam int DRAIN_CYCLES   = 50;
   localparam int HOLD_AT_ITEM   = 30;
   localparam int HOLD_CYCLES    = 2000;
   localparam int PACE_STRETCH   = 16;

   typedef logic [NUMBER_WIDTH-1:0] number_type;

   typedef struct {
      number_type candidate;
      bit         verdict;
   } verdict_item_type;

   // Pacing of the two channels; the bench steps through these as items go in.
   typedef enum int {
      PACE_FREE,
      PACE_SEND_IDLE,
      PACE_RECV_STALL,
      PACE_BOTH
   } pace_type;

   logic clock;
   logic reset;

   tdpt_req_if #(.NUMBER_WIDTH(NUMBER_WIDTH)) req_if ();
   tdpt_rsp_if                                rsp_if ();

   trial_division_prime_test #(
      .NUMBER_WIDTH(NUMBER_WIDTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   number_type       pending_candidates[$];
   verdict_item_type awaited_verdicts[$];
   verdict_item_type oldest_verdict;

   int  directed_items;
   int  total_items;
   int  n_accepted;
   int  n_checked;
   int  errors;
   int  cycles;
   int  hold_count;
   bit  hold_active;
   bit  hold_done;
   bit  req_fire;

   // -------------------------------------------------------------------------
   // Verdict by trial division. The bound is checked as d <= n / d, so the
   // square of the divisor never has to be formed.
   // -------------------------------------------------------------------------
   function automatic bit prime_verdict(input number_type value);
      logic [63:0] n;
      logic [63:0] d;
      bit          verdict;
      n = 64'(value);
      if (n < 64'(SMALLEST_PRIME)) begin
         verdict = 1'b0;
      end else if (n == 64'(SMALLEST_PRIME)) begin
         verdict = 1'b1;
      end else if (!n[0]) begin
         verdict = 1'b0;
      end else begin
         verdict = 1'b1;
         d       = 64'(FIRST_DIVISOR);
         while (verdict && d <= n / d) begin
            if (n % d == '0) begin
               verdict = 1'b0;
            end
            d = d + 64'(DIVISOR_STEP);
         end
      end
      return verdict;
   endfunction

   // Directed items run unpaced; after that, advance one pacing mode per stretch.
   function automatic pace_type pace_now();
      if (n_accepted < directed_items) begin
         return PACE_FREE;
      end
      return pace_type'(((n_accepted - directed_items) / PACE_STRETCH) % 4);
   endfunction

   function automatic int idle_percent(input bit receiver);
      case (pace_now())
         PACE_SEND_IDLE:  return receiver ? 0 : 62;
         PACE_RECV_STALL: return receiver ? 62 : 0;
         PACE_BOTH:       return 16;
         default:         return 0;
      endcase
   endfunction

   function automatic bit roll(input int percent);
      return $urandom_range(99) < percent;
   endfunction

   task automatic report(input string what, input number_type candidate, input bit got,
                         input bit want);
      $display("mismatch on response %0d: %s, candidate %0d, prime_flag %b, expected %b",
               n_checked, what, candidate, got, want);
      errors++;
   endtask

   // -------------------------------------------------------------------------
   // Clock and cycle limit
   // -------------------------------------------------------------------------
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[trial_division_prime_test] ERROR");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Request side: record each accepted item and its predicted verdict
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      req_fire <= !reset && req_if.valid && req_if.ready;
      if (!reset && req_if.valid && req_if.ready) begin
         awaited_verdicts.push_back('{candidate: req_if.candidate,
                                      verdict:   prime_verdict(req_if.candidate)});
         n_accepted <= n_accepted + 1;
      end
   end

   // Drive at the falling edge: hold the item until taken, then offer the next
   // or drop valid. Never idle during the long stall, so the block fills up.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fire) begin
         if (pending_candidates.size() != 0 && (hold_active || !roll(idle_percent(1'b0))))
         begin
            req_if.valid     <= 1'b1;
            req_if.candidate <= pending_candidates.pop_front();
         end else begin
            req_if.valid     <= 1'b0;
            req_if.candidate <= $urandom;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response side: compare each accepted verdict with the oldest prediction
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (awaited_verdicts.size() == 0) begin
            report("no item outstanding", '0, rsp_if.prime_flag, 1'b0);
         end else begin
            oldest_verdict = awaited_verdicts.pop_front();
            if (rsp_if.prime_flag !== oldest_verdict.verdict) begin
               report("wrong verdict", oldest_verdict.candidate, rsp_if.prime_flag,
                      oldest_verdict.verdict);
            end
         end
         n_checked <= n_checked + 1;
      end
   end

   // Long stall: once past the directed items, hold ready low for a fixed stretch.
   always @(posedge clock) begin
      if (!reset && !hold_done && n_accepted >= HOLD_AT_ITEM) begin
         hold_active <= (hold_count < HOLD_CYCLES);
         hold_done   <= (hold_count >= HOLD_CYCLES);
         hold_count  <= hold_count + 1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= !hold_active && !roll(idle_percent(1'b1));
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus and end of run
   // -------------------------------------------------------------------------
   initial begin
      int sel;
      clock            = 1'b0;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.candidate = '0;
      rsp_if.ready     = 1'b0;
      cycles           = 0;
      n_accepted       = 0;
      n_checked        = 0;
      errors           = 0;
      hold_count       = 0;
      hold_active      = 1'b0;
      hold_done        = 1'b0;
      req_fire         = 1'b0;

      // Zero and one, the smallest prime, small composites, small odd primes and
      // squares of primes, where the divisor bound is met exactly.
      pending_candidates = '{0, 1, 2, 3, 4, 5, 7, 9, 15, 25, 49, 97, 121, 961};
      // Largest values: all ones, all ones but bit 0, top bit alone and with bit 0,
      // and both alternating patterns; these stop at a factor of two, three or five.
      pending_candidates.push_back(32'hFFFF_FFFF);
      pending_candidates.push_back(32'hFFFF_FFFE);
      pending_candidates.push_back(32'h8000_0000);
      pending_candidates.push_back(32'h8000_0001);
      pending_candidates.push_back(32'hAAAA_AAAA);
      pending_candidates.push_back(32'h5555_5555);
      // Longer searches: largest 16-bit prime, a prime near a million and a
      // product of two primes near a thousand.
      pending_candidates.push_back(65521);
      pending_candidates.push_back(1_000_003);
      pending_candidates.push_back(997 * 1009);
      directed_items = pending_candidates.size();

      // Keep most random candidates small so that prime searches stay short;
      // reach the upper bits with even values and multiples of three.
      repeat (RANDOM_ITEMS) begin
         sel = $urandom_range(99);
         if (sel < 55) begin
            pending_candidates.push_back($urandom_range(1023));
         end else if (sel < 80) begin
            pending_candidates.push_back($urandom_range(65535));
         end else if (sel < 90) begin
            pending_candidates.push_back(number_type'({$urandom_range(32'h7FFF_FFFF), 1'b0}));
         end else begin
            pending_candidates.push_back(3 * $urandom_range(32'h5555_5555, 1));
         end
      end
      total_items = pending_candidates.size();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (n_accepted < total_items || n_checked < total_items) begin
         @(negedge clock);
      end
      // Run on for DRAIN_CYCLES so that a stray response would still be seen.
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (errors == 0) begin
         $display("[trial_division_prime_test] OK");
      end else begin
         $display("[trial_division_prime_test] ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/tdpt_pkg.sv
src/tdpt_channels.sv
src/tdpt_divider.sv
src/trial_division_prime_test.sv
test/tb_trial_division_prime_test.sv
